// ===== src/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the stereo crosstalk canceller: request
// payloads, lane control, sample limits and the crossfeed coefficient table.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int HIST_DEPTH = 128;
    localparam int HIST_AW    = 7;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } in_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_req_t;

    typedef struct packed {
        logic clear;
        logic tap_en;
        logic dir_en;
    } lane_ctrl_t;

    localparam logic signed [COEF_W-1:0] XFEED_ROM [HIST_DEPTH] = '{
        16'sd296,   -16'sd341,  -16'sd533,  -16'sd200,  16'sd259,   16'sd435,   16'sd76,
        -16'sd248,  -16'sd444,  -16'sd183,  16'sd262,   16'sd494,   16'sd115,   -16'sd435,
        -16'sd437,  16'sd120,   16'sd510,   16'sd199,   -16'sd86,   -16'sd208,  -16'sd157,
        -16'sd196,  16'sd311,   16'sd552,   16'sd343,   -16'sd1044, 16'sd111,   -16'sd533,
        16'sd2020,  -16'sd1876, 16'sd1684,  -16'sd3154, -16'sd22753, -16'sd3320, 16'sd648,
        -16'sd1685, 16'sd467,   -16'sd1677, 16'sd599,   16'sd43,    16'sd583,   -16'sd165,
        -16'sd666,  -16'sd888,  -16'sd538,  16'sd584,   16'sd315,   16'sd415,   -16'sd464,
        -16'sd509,  -16'sd140,  16'sd392,   16'sd459,   16'sd272,   -16'sd676,  -16'sd1191,
        -16'sd111,  16'sd769,   16'sd630,   16'sd124,   -16'sd150,  -16'sd351,  16'sd58,
        16'sd266,   16'sd161,   -16'sd540,  -16'sd1020, -16'sd1052, 16'sd81,    16'sd885,
        16'sd557,   -16'sd280,  -16'sd761,  -16'sd202,  16'sd355,   16'sd649,   -16'sd133,
        -16'sd529,  -16'sd369,  16'sd230,   16'sd886,   16'sd531,   16'sd68,    -16'sd501,
        -16'sd191,  16'sd230,   16'sd566,   16'sd384,   -16'sd278,  -16'sd522,  -16'sd328,
        16'sd239,   16'sd564,   16'sd345,   -16'sd247,  -16'sd548,  -16'sd253,  16'sd225,
        16'sd532,   16'sd138,   -16'sd340,  -16'sd614,  -16'sd216,  16'sd297,   16'sd455,
        16'sd119,   -16'sd517,  -16'sd558,  -16'sd114,  16'sd427,   16'sd556,   16'sd42,
        -16'sd443,  -16'sd453,  16'sd59,    16'sd582,   16'sd501,   16'sd13,    -16'sd456,
        -16'sd284,  16'sd118,   16'sd532,   16'sd277,   -16'sd101,  -16'sd505,  -16'sd291,
        16'sd226,   16'sd491
    };

endpackage

// ===== src/scc_hist.sv =====
// ----------------------------------------------------------------------------
// scc_hist
// One channel's sample history: 128-entry memory with one write port and one
// registered read port. Per-entry valid bits make unwritten slots read zero.
// ----------------------------------------------------------------------------
module scc_hist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [scc_pkg::HIST_AW-1:0]          wr_addr,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic                                 rd_en,
    input  logic [scc_pkg::HIST_AW-1:0]          rd_addr,
    output logic signed [scc_pkg::SAMPLE_W-1:0]  rd_data
);
    import scc_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]      vld_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/scc_mac_lane.sv =====
// ----------------------------------------------------------------------------
// scc_mac_lane
// One output channel's multiply-accumulate lane: registered product, wide
// accumulator and capture of the direct-path sample.
// ----------------------------------------------------------------------------
module scc_mac_lane #(
    parameter int ACC_W = 40
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  scc_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [scc_pkg::COEF_W-1:0]    coef,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]  cross_sample,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]  direct_sample,
    output logic signed [ACC_W-1:0]              acc,
    output logic signed [scc_pkg::SAMPLE_W-1:0]  direct,
    output logic                                 busy
);
    import scc_pkg::*;

    logic                       prod_valid_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.tap_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tap_en)
        begin
            prod_reg <= coef * cross_sample;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.dir_en)
        begin
            direct_reg <= direct_sample;
        end
    end

    assign acc    = acc_reg;
    assign direct = direct_reg;
    assign busy   = prod_valid_reg;

endmodule

// ===== src/scc_merge.sv =====
// ----------------------------------------------------------------------------
// scc_merge
// Combine both lanes: scale the sums, add the direct path, apply the 3/4 gain,
// saturate and hold the result request in the output register.
// ----------------------------------------------------------------------------
module scc_merge #(
    parameter int ACC_W         = 40,
    parameter int PRODUCT_SHIFT = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic signed [ACC_W-1:0]              acc_l,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]  direct_l,
    input  logic signed [ACC_W-1:0]              acc_r,
    input  logic signed [scc_pkg::SAMPLE_W-1:0]  direct_r,
    output logic                                 free,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output scc_pkg::out_req_t                    out_data
);
    import scc_pkg::*;

    localparam int V_W = ACC_W + 1;
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(SAMPLE_MAX);
    localparam logic signed [V_W-1:0] SAT_LO = V_W'(SAMPLE_MIN);

    function automatic logic signed [SAMPLE_W-1:0] finish(
        input logic signed [ACC_W-1:0]    a,
        input logic signed [SAMPLE_W-1:0] d
    );
        logic signed [ACC_W-1:0] shifted;
        logic signed [V_W-1:0]   v;
        logic signed [V_W-1:0]   s;
        logic signed [SAMPLE_W-1:0] r;
        shifted = a >>> PRODUCT_SHIFT;
        v = V_W'(shifted) + V_W'(d);
        s = (v >>> 1) + (v >>> 2);
        if (s > SAT_HI)
        begin
            r = SAMPLE_W'(SAT_HI);
        end
        else if (s < SAT_LO)
        begin
            r = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            r = SAMPLE_W'(s);
        end
        return r;
    endfunction

    logic     out_valid_reg;
    out_req_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.left_out  <= finish(acc_l, direct_l);
            out_data_reg.right_out <= finish(acc_r, direct_r);
        end
    end

    assign free      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result loaded over a pending request");
`endif

endmodule

// ===== src/stereo_crosstalk_canceller_core.sv =====
// ----------------------------------------------------------------------------
// stereo_crosstalk_canceller_core
// Stereo crosstalk canceller: each output is the opposite channel's history
// through a 128-tap crossfeed FIR, plus the delayed same-channel sample,
// scaled by 3/4 and saturated to 16 bits.
//
// Usage:
//   in_valid/in_ready/in_data carry one stereo sample pair per request;
//   out_valid/out_ready/out_data carry one cancelled pair per request.
//   Two MAC lanes (left, right) step through the taps together, one tap per
//   cycle, reading both history memories at the same slot each cycle.
//   An accepted pair passes through ST_RUN and ST_DRAIN before out_valid.
//   A new pair is taken only in ST_IDLE; the pace is set by the single
//   read port of each history memory walking TAPS taps plus the direct tap.
//   The next input is accepted while the previous result waits; a result
//   that finds the output register still full holds the lanes until
//   out_ready frees it.
//   Reset clears both histories (per-slot valid bits) and the write slot;
//   the block is ready for input in the first cycle after reset.
// ----------------------------------------------------------------------------
module stereo_crosstalk_canceller_core #(
    parameter int TAPS          = 128,
    parameter int DIRECT_DELAY  = 30,
    parameter int PRODUCT_SHIFT = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scc_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output scc_pkg::out_req_t out_data
);
    import scc_pkg::*;

    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(TAPS);
    localparam logic [HIST_AW-1:0] DLY      = HIST_AW'(DIRECT_DELAY);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [HIST_AW-1:0]  pos_reg, pos_next;
    logic                iss_tap_reg, iss_dir_reg;
    logic signed [COEF_W-1:0] coef_reg;

    logic                accept, load, issue, merge_free;
    logic [HIST_AW-1:0]  rd_addr;
    logic signed [SAMPLE_W-1:0] left_rd, right_rd;
    logic signed [ACC_W-1:0]    acc_l, acc_r;
    logic signed [SAMPLE_W-1:0] direct_l, direct_r;
    logic                busy_l, busy_r;
    lane_ctrl_t          lane_ctrl;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_RUN);
    assign rd_addr  = (cnt_reg == LAST_CNT) ? (pos_reg - DLY)
                                            : (pos_reg - HIST_AW'(cnt_reg));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!iss_tap_reg && !iss_dir_reg && !busy_l && !busy_r && merge_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    pos_next   = pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            iss_tap_reg <= 1'b0;
            iss_dir_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            iss_tap_reg <= issue && (cnt_reg != LAST_CNT);
            iss_dir_reg <= issue && (cnt_reg == LAST_CNT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            coef_reg <= XFEED_ROM[HIST_AW'(cnt_reg)];
        end
    end

    assign lane_ctrl.clear  = accept;
    assign lane_ctrl.tap_en = iss_tap_reg;
    assign lane_ctrl.dir_en = iss_dir_reg;

    scc_hist u_hist_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (pos_reg),
        .wr_data (in_data.left_in),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (left_rd)
    );

    scc_hist u_hist_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (pos_reg),
        .wr_data (in_data.right_in),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (right_rd)
    );

    scc_mac_lane #(.ACC_W(ACC_W)) u_lane_l (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (lane_ctrl),
        .coef          (coef_reg),
        .cross_sample  (right_rd),
        .direct_sample (left_rd),
        .acc           (acc_l),
        .direct        (direct_l),
        .busy          (busy_l)
    );

    scc_mac_lane #(.ACC_W(ACC_W)) u_lane_r (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (lane_ctrl),
        .coef          (coef_reg),
        .cross_sample  (left_rd),
        .direct_sample (right_rd),
        .acc           (acc_r),
        .direct        (direct_r),
        .busy          (busy_r)
    );

    scc_merge #(.ACC_W(ACC_W), .PRODUCT_SHIFT(PRODUCT_SHIFT)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .acc_l     (acc_l),
        .direct_l  (direct_l),
        .acc_r     (acc_r),
        .direct_r  (direct_r),
        .free      (merge_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted twice without computing");

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!iss_tap_reg && !iss_dir_reg && !busy_l && !busy_r))
        else $error("result loaded before lanes drained");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("write slot did not advance after result");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_CNT)
        else $error("tap counter out of range");
`endif

endmodule
